// ===== sv/sobel_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and state encodings of the Sobel edge block.
package sobel_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int LANES      = 3;
  localparam int GRAD_W     = CH_W + 3;
  localparam int SQ_W       = 2 * (CH_W + 2);
  localparam int S4_W       = SQ_W + 3;
  localparam int STEP_W     = $clog2(CH_W);
  localparam int ADDR_W     = 3;

  localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [FW_W-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]   HEIGHT_RST = 13'd480;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef logic [2:0][2:0][CH_W-1:0] chan_win_t;

  typedef enum logic [1:0] {PH_IDLE, PH_SQ, PH_SUM, PH_ROOT} lane_ph_t;
  typedef enum logic [2:0] {CS_IDLE, CS_READ, CS_EMIT, CS_WAIT, CS_PUSH} ctl_st_t;
endpackage

// ===== sv/sobel_if.sv =====
`timescale 1ns / 1ps
// Stream interfaces: pixel words in, gradient words out.
interface sobel_pix_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface sobel_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       run_end;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, run_end, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, run_end, frame_end,
                  output ready);
endinterface

// ===== sv/sobel_ram.sv =====
`timescale 1ns / 1ps
// Single-port line store, one pixel per entry, registered read.
module sobel_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sobel_pkg::COL_W-1:0] addr,
  input  logic [sobel_pkg::PIX_W-1:0] wdata,
  output logic [sobel_pkg::PIX_W-1:0] rdata
);
  import sobel_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/sobel_lane.sv =====
`timescale 1ns / 1ps
// One colour lane: Sobel gradients, sum of squares, bit-serial rounded root.
module sobel_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sobel_pkg::chan_win_t px,
  output logic                 done,
  output logic [sobel_pkg::CH_W-1:0] mag
);
  import sobel_pkg::*;

  lane_ph_t ph, ph_next;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [GRAD_W-1:0] gx_c, gy_c;
  logic [CH_W+1:0]  sl, sr, st, sb;
  logic [SQ_W-1:0]  sqx, sqy;
  logic [S4_W-1:0]  s4;
  logic [STEP_W-1:0] bitn;
  logic [CH_W-1:0]  n, trial;
  logic [CH_W:0]    d;
  logic [2*CH_W+1:0] dd;
  logic             fits;

  always_comb begin
    sl = {2'b0, px[0][0]} + {1'b0, px[1][0], 1'b0} + {2'b0, px[2][0]};
    sr = {2'b0, px[0][2]} + {1'b0, px[1][2], 1'b0} + {2'b0, px[2][2]};
    st = {2'b0, px[0][0]} + {1'b0, px[0][1], 1'b0} + {2'b0, px[0][2]};
    sb = {2'b0, px[2][0]} + {1'b0, px[2][1], 1'b0} + {2'b0, px[2][2]};
    gx_c = $signed({1'b0, sr}) - $signed({1'b0, sl});
    gy_c = $signed({1'b0, sb}) - $signed({1'b0, st});
    // trial root t passes when (2t-1)^2 <= 4s
    trial = n | (CH_W'(1) << bitn);
    d     = {trial, 1'b0} - (CH_W+1)'(1);
    dd    = d * d;
    fits  = {{(S4_W-2*CH_W-2){1'b0}}, dd} <= s4;
  end

  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_IDLE: if (start) ph_next = PH_SQ;
      PH_SQ:   ph_next = PH_SUM;
      PH_SUM:  ph_next = PH_ROOT;
      PH_ROOT: if (bitn == '0) ph_next = PH_IDLE;
      default: ph_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      ph   <= ph_next;
      done <= (ph == PH_ROOT) && (bitn == '0);
    end
    unique case (ph)
      PH_IDLE: begin
        if (start) begin
          gx <= gx_c;
          gy <= gy_c;
        end
      end
      PH_SQ: begin
        sqx <= SQ_W'(gx * gx);
        sqy <= SQ_W'(gy * gy);
      end
      PH_SUM: begin
        s4   <= {({1'b0, sqx} + {1'b0, sqy}), 2'b00};
        n    <= '0;
        bitn <= STEP_W'(CH_W - 1);
      end
      PH_ROOT: begin
        if (fits) begin
          n <= trial;
        end
        bitn <= bitn - STEP_W'(1);
      end
      default: ;
    endcase
  end

  assign mag = n;
endmodule

// ===== sv/sobel_edge_magnitude_rgb.sv =====
`timescale 1ns / 1ps
// Top level: raster control, line stores, 3x3 window, colour lanes, output word.
// One word at a time: a new word is taken only once every result of the last one has
// been pushed; the receiver can hold off a result. Each lane finds its root bit-serially
// in 8 steps.
// First result leaves one row plus one pixel after the pixel it belongs to.
// Synchronous reset clears counters, window and control; no clearing pass of the line stores.
module sobel_edge_magnitude_rgb (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [sobel_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  sobel_pix_if.sink          pix,
  sobel_res_if.source        res
);
  import sobel_pkg::*;

  // configuration
  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;
  logic [FW_W-1:0] w_sat;
  logic [FH_W-1:0] h_sat;

  // raster position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // per-word context held while it is worked off
  logic [PIX_W-1:0] bot_q;
  logic [COL_W-1:0] col_q;
  logic             col0_q, row1_q, row2_q, last_q, drain_q;
  logic             pend1, pend2, zshift;
  logic             re_q, fe_q;

  logic [2:0][2:0][PIX_W-1:0] win;
  logic [PIX_W-1:0] up_rd, mid_rd, top_px, mid_px;

  ctl_st_t st, st_next;
  logic    accept, drain, is_last, kind_ok;
  logic    mem_we, lane_start, load_out;
  logic    out_free;

  chan_win_t             cw   [LANES];
  logic [LANES-1:0]      done;
  logic [CH_W-1:0]       mag  [LANES];

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= WIDTH_RST;
      fh <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_WIDTH:  fw <= pwdata[FW_W-1:0];
        REG_HEIGHT: fh <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_WIDTH:  prdata = {{(32-FW_W){1'b0}}, fw};
      REG_HEIGHT: prdata = {{(32-FH_W){1'b0}}, fh};
      default:    prdata = '0;
    endcase
  end

  // out-of-range sizes saturate
  always_comb begin
    if (fw == '0)                      w_sat = FW_W'(1);
    else if (fw > FW_W'(MAX_WIDTH))    w_sat = FW_W'(MAX_WIDTH);
    else                               w_sat = fw;
    if (fh == '0)                      h_sat = FH_W'(1);
    else if (fh > FH_W'(MAX_HEIGHT))   h_sat = FH_W'(MAX_HEIGHT);
    else                               h_sat = fh;
  end

  assign drain   = row >= ROW_W'(h_sat);
  assign is_last = ({1'b0, col} + (COL_W+1)'(1)) >= (COL_W+1)'(w_sat);
  assign kind_ok = pix.func == (drain ? FUNC_DRAIN : FUNC_PIXEL);
  assign accept  = pix.valid && pix.ready;
  assign out_free = !res.valid || res.ready;

  // control sequencer
  always_comb begin
    st_next    = st;
    pix.ready  = 1'b0;
    mem_we     = 1'b0;
    lane_start = 1'b0;
    load_out   = 1'b0;
    unique case (st)
      CS_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid && kind_ok) st_next = CS_READ;
      end
      CS_READ: begin
        mem_we  = !drain_q;
        st_next = CS_EMIT;
      end
      CS_EMIT: begin
        if (pend1) begin
          lane_start = 1'b1;
          st_next    = CS_WAIT;
        end else if (last_q && !zshift) begin
          st_next = CS_EMIT;
        end else if (pend2) begin
          lane_start = 1'b1;
          st_next    = CS_WAIT;
        end else begin
          st_next = CS_IDLE;
        end
      end
      CS_WAIT: begin
        if (done[0]) st_next = CS_PUSH;
      end
      CS_PUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          st_next  = CS_EMIT;
        end
      end
      default: st_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CS_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // line stores
  sobel_ram u_upper (
    .clk   (clk),
    .we    (mem_we),
    .addr  (accept ? col : col_q),
    .wdata (mid_px),
    .rdata (up_rd)
  );

  sobel_ram u_middle (
    .clk   (clk),
    .we    (mem_we),
    .addr  (accept ? col : col_q),
    .wdata (bot_q),
    .rdata (mid_rd)
  );

  // rows above the frame read as zero
  assign top_px = row2_q ? up_rd  : '0;
  assign mid_px = row1_q ? mid_rd : '0;

  // counters, word context and window
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      win    <= '0;
      pend1  <= 1'b0;
      pend2  <= 1'b0;
      zshift <= 1'b0;
    end else begin
      unique case (st)
        CS_IDLE: begin
          if (accept && kind_ok) begin
            bot_q   <= drain ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
            col_q   <= col;
            col0_q  <= col == '0;
            row1_q  <= row >= ROW_W'(1);
            row2_q  <= row >= ROW_W'(2);
            last_q  <= is_last;
            drain_q <= drain;
            zshift  <= 1'b0;
            if (is_last) begin
              col <= '0;
              row <= drain ? '0 : row + ROW_W'(1);
            end else begin
              col <= col + COL_W'(1);
            end
          end
        end
        CS_READ: begin
          for (int k = 0; k < 3; k++) begin
            win[k][0] <= col0_q ? '0 : win[k][1];
            win[k][1] <= col0_q ? '0 : win[k][2];
          end
          win[0][2] <= top_px;
          win[1][2] <= mid_px;
          win[2][2] <= bot_q;
          pend1 <= row1_q && !col0_q;
          pend2 <= row1_q && last_q;
        end
        CS_EMIT: begin
          if (pend1) begin
            pend1 <= 1'b0;
            re_q  <= !last_q;
            fe_q  <= 1'b0;
          end else if (last_q && !zshift) begin
            // step past the right edge
            for (int k = 0; k < 3; k++) begin
              win[k][0] <= win[k][1];
              win[k][1] <= win[k][2];
              win[k][2] <= '0;
            end
            zshift <= 1'b1;
          end else if (pend2) begin
            pend2 <= 1'b0;
            re_q  <= 1'b1;
            fe_q  <= drain_q;
          end
        end
        default: ;
      endcase
    end
  end

  // colour lanes: lane 0 blue, 1 green, 2 red
  for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          cw[ln][a][b] = win[a][b][ln*CH_W +: CH_W];
        end
      end
    end

    sobel_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .px    (cw[ln]),
      .done  (done[ln]),
      .mag   (mag[ln])
    );
  end

  // merge lanes into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (load_out) begin
      res.red_out   <= mag[2];
      res.green_out <= mag[1];
      res.blue_out  <= mag[0];
      res.run_end   <= re_q;
      res.frame_end <= fe_q;
    end
  end

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    done[0] == done[1] && done[1] == done[2])
    else $error("colour lanes out of step");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> !pend1 && !pend2)
    else $error("word taken while results still pending");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output word overwritten");

  a_start_after_done: assert property (@(posedge clk) disable iff (rst)
    lane_start |=> !lane_start)
    else $error("lane restarted back to back");
endmodule

// ===== test/sobel_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Sobel edge block: watches register writes and both word streams.
module sobel_checker (
  input  logic  clk,
  input  logic  rst,
  input  logic  psel,
  input  logic  penable,
  input  logic  pwrite,
  input  logic  pready,
  input  logic [sobel_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  sobel_pix_if  pix,
  sobel_res_if  res,
  output int    fails,
  output int    pending
);
  import sobel_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_end;
    logic       frame_end;
  } grad_word_t;

  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int               col;
  int               row;
  grad_word_t       grad_q [$];

  assign pending = grad_q.size();

  function automatic logic [7:0] edge_mag(int sh);
    int p [3][3];
    int gx, gy, s4, n;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) p[a][b] = (win[a][b] >> sh) & 8'hff;
    gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
    gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
    s4 = 4 * (gx * gx + gy * gy);
    n = 0;
    while (n < 255 && (2 * n + 1) * (2 * n + 1) <= s4) n++;
    return n[7:0];
  endfunction

  task automatic shift_in(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m, logic [PIX_W-1:0] b);
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = t;
    win[1][2] = m;
    win[2][2] = b;
  endtask

  task automatic push_grad(logic last, logic fend);
    grad_word_t g;
    g.red       = edge_mag(16);
    g.green     = edge_mag(8);
    g.blue      = edge_mag(0);
    g.run_end   = last;
    g.frame_end = fend;
    grad_q.push_back(g);
  endtask

  // one accepted input word through the raster predictor
  task automatic take_word(logic fn, logic [PIX_W-1:0] px);
    int w, h, c;
    logic drain, last;
    logic [PIX_W-1:0] t, m, b;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    drain = (row >= h);
    if (fn != drain) return;  // wrong kind: dropped
    c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
    last = (col + 1 >= w);
    t = (row >= 2) ? upper_row[c] : '0;
    m = (row >= 1) ? middle_row[c] : '0;
    b = drain ? '0 : px;
    if (!drain) begin
      upper_row[c]  = m;
      middle_row[c] = b;
    end
    if (col == 0)
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 3; k++) win[a][k] = '0;
    shift_in(t, m, b);
    if (row >= 1 && col >= 1) push_grad(!last, 1'b0);
    if (last) begin
      shift_in('0, '0, '0);
      if (row >= 1) push_grad(1'b1, drain);
      col = 0;
      row = drain ? 0 : row + 1;
    end else begin
      col++;
    end
  endtask

  task automatic check_grad();
    grad_word_t g;
    if (grad_q.size() == 0) begin
      $error("gradient word with none expected");
      fails++;
      return;
    end
    g = grad_q.pop_front();
    if (res.red_out !== g.red) begin
      $error("red_out: expected %0d, got %0d", g.red, res.red_out); fails++;
    end
    if (res.green_out !== g.green) begin
      $error("green_out: expected %0d, got %0d", g.green, res.green_out); fails++;
    end
    if (res.blue_out !== g.blue) begin
      $error("blue_out: expected %0d, got %0d", g.blue, res.blue_out); fails++;
    end
    if (res.run_end !== g.run_end) begin
      $error("run_end: expected %0d, got %0d", g.run_end, res.run_end); fails++;
    end
    if (res.frame_end !== g.frame_end) begin
      $error("frame_end: expected %0d, got %0d", g.frame_end, res.frame_end); fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      col = 0;
      row = 0;
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 3; k++) win[a][k] = '0;
      grad_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_WIDTH)  width_reg  = pwdata[FW_W-1:0];
        if (paddr == REG_HEIGHT) height_reg = pwdata[FH_W-1:0];
      end
      if (res.valid && res.ready) check_grad();
      if (pix.valid && pix.ready)
        take_word(pix.func, {pix.red_in, pix.green_in, pix.blue_in});
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the Sobel edge testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import sobel_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // cycles with no word moved before giving up
  localparam int SETTLE      = 40;     // beyond the longest per-word latency

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fails;
  int                 pending;
  int                 src_idle_pct;
  int                 snk_stall_pct;
  int                 quiet;
  int                 eff_w;
  int                 eff_h;
  int                 counted;
  bit                 paused_once;

  sobel_pix_if pix ();
  sobel_res_if res ();

  sobel_edge_magnitude_rgb DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix(pix), .res(res)
  );

  sobel_checker checker_i (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .pix(pix), .res(res),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure, re-rolled every cycle
  always @(negedge clk) res.ready <= ($urandom_range(99) >= snk_stall_pct);

  // watchdog: any accepted word, on either stream or the register port, resets it
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lighter
  task automatic set_idling(int mode);
    src_idle_pct  = (mode == 1) ? 77 : (mode == 3 ? 32 : 0);
    snk_stall_pct = (mode == 2) ? 77 : (mode == 3 ? 32 : 0);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // block drained: all words back, plus time for a word with no result still in flight
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_frame(int raw_w, int raw_h);
    wait_drained();
    reg_write(REG_WIDTH, raw_w);
    reg_write(REG_HEIGHT, raw_h);
    eff_w = (raw_w < 1) ? 1 : (raw_w > MAX_WIDTH ? MAX_WIDTH : raw_w);
    eff_h = (raw_h < 1) ? 1 : (raw_h > MAX_HEIGHT ? MAX_HEIGHT : raw_h);
  endtask

  task automatic send_word(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid    <= 1'b1;
    pix.func     <= fn;
    pix.red_in   <= r;
    pix.green_in <= g;
    pix.blue_in  <= b;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return $urandom_range(255);
    endcase
  endfunction

  // full frame plus drain row; noise_pct of the slots get a wrong-kind word first
  task automatic run_frame(int noise_pct);
    for (int r = 0; r < eff_h; r++) begin
      for (int c = 0; c < eff_w; c++) begin
        if ($urandom_range(99) < noise_pct)
          send_word(FUNC_DRAIN, rand_chan(), rand_chan(), rand_chan());
        send_word(FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
        counted++;
      end
      // pause the sender once until the block has caught up
      if (!paused_once && r == 1) begin
        pix.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        paused_once = 1;
      end
    end
    for (int c = 0; c < eff_w; c++) begin
      if ($urandom_range(99) < noise_pct)
        send_word(FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
      send_word(FUNC_DRAIN, rand_chan(), rand_chan(), rand_chan());
      counted++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.func     = FUNC_PIXEL;
    pix.red_in   = '0;
    pix.green_in = '0;
    pix.blue_in  = '0;
    counted      = 0;
    paused_once  = 0;
    set_idling(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 3x3 frame with stray drain tick, hard edges, stray pixel in drain row
    set_frame(3, 3);
    send_word(FUNC_DRAIN, 8'hff, 8'hff, 8'hff);
    for (int k = 0; k < 9; k++)
      send_word(FUNC_PIXEL, (k % 3 == 0) ? 8'hff : 8'h00, (k < 3) ? 8'hff : 8'h00,
                (k % 2) ? 8'hff : 8'h00);
    send_word(FUNC_PIXEL, 8'h55, 8'haa, 8'h0f);
    for (int k = 0; k < 3; k++) send_word(FUNC_DRAIN, 8'h00, 8'h00, 8'h00);
    // single pixel frame, then next frame straight after the drain
    set_frame(1, 1);
    send_word(FUNC_PIXEL, 8'hff, 8'h00, 8'h80);
    send_word(FUNC_DRAIN, 8'h00, 8'h00, 8'h00);
    send_word(FUNC_PIXEL, 8'h01, 8'hfe, 8'h7f);
    send_word(FUNC_DRAIN, 8'hff, 8'hff, 8'hff);

    // zero in both registers saturates up to one
    set_frame(0, 0);
    run_frame(2);
    set_frame(0, 2);
    run_frame(2);

    // random frames, mostly small, idling mode cycled
    counted = 0;
    while (counted < 650) begin
      set_idling($urandom_range(3));
      if ($urandom_range(9) == 0) set_frame($urandom_range(13, 40), $urandom_range(1, 3));
      else set_frame($urandom_range(1, 12), $urandom_range(1, 6));
      run_frame($urandom_range(1) ? 0 : 6);
    end

    pix.valid <= 1'b0;
    set_idling(0);
    wait_drained();
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/sobel_pkg.sv
sv/sobel_if.sv
sv/sobel_ram.sv
sv/sobel_lane.sv
sv/sobel_edge_magnitude_rgb.sv
test/sobel_checker.sv
test/testbench.sv
